/* rtl/gfm_pkg.sv */
// shared types, constants and helper functions of the grid fan mesh index generator
package gfm_pkg;

  localparam int DIM_W           = 11;
  localparam int IDX_W           = 20;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 1;
  localparam int CFG_W           = (COORD_W > DIM_W) ? COORD_W : DIM_W;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int NTRI            = 8;
  localparam int TRI_W           = 3;
  localparam int QDEPTH          = 2;
  localparam int OUT_BITS        = IDX_W + 4 * COORD_W;
  localparam int OUT_W           = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_W            = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_STEP_A  = 2'd2,
    REG_STEP_B  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    CN_C  = 4'd0,
    CN_UL = 4'd1,
    CN_UC = 4'd2,
    CN_UR = 4'd3,
    CN_CL = 4'd4,
    CN_CR = 4'd5,
    CN_LL = 4'd6,
    CN_LC = 4'd7,
    CN_LR = 4'd8
  } corner_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_z;
    logic [COORD_W-1:0] tex_u;
    logic [COORD_W-1:0] tex_v;
    logic               center;
    logic [NTRI-1:0]    tri_mask;
  } desc_t;

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_W] ? {COORD_W{1'b1}} : s[COORD_W-1:0];
  endfunction

  // second and third corner of each fan triangle, first is always the center
  function automatic corner_t fan_corner(input logic [TRI_W-1:0] t, input logic second);
    corner_t c;
    unique case (t)
      3'd0: c = second ? CN_CL : CN_UL;
      3'd1: c = second ? CN_UL : CN_UC;
      3'd2: c = second ? CN_UC : CN_UR;
      3'd3: c = second ? CN_UR : CN_CR;
      3'd4: c = second ? CN_CR : CN_LR;
      3'd5: c = second ? CN_LR : CN_LC;
      3'd6: c = second ? CN_LC : CN_LL;
      3'd7: c = second ? CN_LL : CN_CL;
    endcase
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] corner_index(input logic [IDX_W-1:0] c,
                                                     input logic [IDX_W-1:0] cols,
                                                     input corner_t sel);
    logic [IDX_W-1:0] r;
    unique case (sel)
      CN_C:    r = c;
      CN_UL:   r = c - cols - IDX_W'(1);
      CN_UC:   r = c - cols;
      CN_UR:   r = c - cols + IDX_W'(1);
      CN_CL:   r = c - IDX_W'(1);
      CN_CR:   r = c + IDX_W'(1);
      CN_LL:   r = c + cols - IDX_W'(1);
      CN_LC:   r = c + cols;
      CN_LR:   r = c + cols + IDX_W'(1);
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

/* rtl/gfm_front.sv */
// front end: configuration registers, grid walk state and step classification
module gfm_front #(
  parameter int MAX_COLUMNS = gfm_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gfm_pkg::MAX_ROWS_DEF,
  localparam int COL_W = $clog2(MAX_COLUMNS),
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int CD_W  = $clog2(MAX_COLUMNS + 1),
  localparam int RD_W  = $clog2(MAX_ROWS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           step,
  input  logic                           restart,
  output gfm_pkg::desc_t                 desc,
  output logic [CD_W-1:0]                cols
);

  logic [gfm_pkg::DIM_W-1:0]   grid_cols_r, grid_rows_r;
  logic [gfm_pkg::COORD_W-1:0] step_a_r, step_b_r;

  logic [ROW_W-1:0]            row_r, row_nxt, e_row;
  logic [COL_W-1:0]            col_r, col_nxt, e_col;
  logic [gfm_pkg::IDX_W-1:0]   idx_r, idx_nxt, e_idx;
  logic [gfm_pkg::COORD_W-1:0] csb_r, csb_nxt, e_csb;
  logic [gfm_pkg::COORD_W-1:0] csa_r, csa_nxt, e_csa;
  logic [gfm_pkg::COORD_W-1:0] rsa_r, rsa_nxt, e_rsa;
  logic [gfm_pkg::COORD_W-1:0] rsb_r, rsb_nxt, e_rsb;

  logic [RD_W-1:0] rows;
  logic            clear, last_row, last_col, wrap_col, wrap_row;
  logic [31:0]     gc32, gr32;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= gfm_pkg::DIM_W'(2);
      grid_rows_r <= gfm_pkg::DIM_W'(2);
      step_a_r    <= gfm_pkg::COORD_W'(1 << gfm_pkg::COORD_FRAC_BITS);
      step_b_r    <= gfm_pkg::COORD_W'(1 << gfm_pkg::COORD_FRAC_BITS);
    end else if (cfg_valid) begin
      unique case (gfm_pkg::cfg_reg_t'(cfg_index))
        gfm_pkg::REG_COLUMNS: grid_cols_r <= cfg_data[gfm_pkg::DIM_W-1:0];
        gfm_pkg::REG_ROWS:    grid_rows_r <= cfg_data[gfm_pkg::DIM_W-1:0];
        gfm_pkg::REG_STEP_A:  step_a_r    <= cfg_data[gfm_pkg::COORD_W-1:0];
        gfm_pkg::REG_STEP_B:  step_b_r    <= cfg_data[gfm_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // dimensions clamped to the supported range
  assign gc32 = 32'(grid_cols_r);
  assign gr32 = 32'(grid_rows_r);
  assign cols = (gc32 < 32'd2) ? CD_W'(2) :
                (gc32 > 32'(MAX_COLUMNS)) ? CD_W'(MAX_COLUMNS) : CD_W'(gc32);
  assign rows = (gr32 < 32'd2) ? RD_W'(2) :
                (gr32 > 32'(MAX_ROWS)) ? RD_W'(MAX_ROWS) : RD_W'(gr32);

  always_comb begin
    clear = restart || (32'(row_r) >= 32'(rows)) || (32'(col_r) >= 32'(cols));
    e_row = clear ? '0 : row_r;
    e_col = clear ? '0 : col_r;
    e_idx = clear ? '0 : idx_r;
    e_csb = clear ? '0 : csb_r;
    e_csa = clear ? '0 : csa_r;
    e_rsa = clear ? '0 : rsa_r;
    e_rsb = clear ? '0 : rsb_r;

    last_row = (32'(e_row) + 32'd1) == 32'(rows);
    last_col = (32'(e_col) + 32'd1) == 32'(cols);

    desc.idx      = e_idx;
    desc.pos_x    = e_csb;
    desc.pos_z    = e_rsa;
    desc.tex_u    = e_rsb;
    desc.tex_v    = e_csa;
    desc.center   = e_row[0] & e_col[0];
    desc.tri_mask = 8'b0000_0011;
    if (!last_row && last_col) begin
      desc.tri_mask[7:6] = 2'b11;
    end else if (last_row && !last_col) begin
      desc.tri_mask[3:2] = 2'b11;
    end else if (!last_row && !last_col) begin
      desc.tri_mask[7:2] = 6'b11_1111;
    end

    wrap_col = last_col;
    wrap_row = last_row;
    idx_nxt  = e_idx + gfm_pkg::IDX_W'(1);
    col_nxt  = COL_W'(e_col + COL_W'(1));
    row_nxt  = e_row;
    csb_nxt  = gfm_pkg::sat_add(e_csb, step_b_r);
    csa_nxt  = gfm_pkg::sat_add(e_csa, step_a_r);
    rsa_nxt  = e_rsa;
    rsb_nxt  = e_rsb;
    if (wrap_col) begin
      col_nxt = '0;
      csb_nxt = '0;
      csa_nxt = '0;
      row_nxt = ROW_W'(e_row + ROW_W'(1));
      rsa_nxt = gfm_pkg::sat_add(e_rsa, step_a_r);
      rsb_nxt = gfm_pkg::sat_add(e_rsb, step_b_r);
      if (wrap_row) begin
        row_nxt = '0;
        idx_nxt = '0;
        rsa_nxt = '0;
        rsb_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      idx_r <= '0;
      csb_r <= '0;
      csa_r <= '0;
      rsa_r <= '0;
      rsb_r <= '0;
    end else if (step) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      idx_r <= idx_nxt;
      csb_r <= csb_nxt;
      csa_r <= csa_nxt;
      rsa_r <= rsa_nxt;
      rsb_r <= rsb_nxt;
    end
  end

endmodule

/* rtl/gfm_queue.sv */
// short descriptor queue between front and back end
module gfm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gfm_pkg::desc_t push_desc,
  output logic           push_ready,
  input  logic           pop,
  output logic           head_valid,
  output gfm_pkg::desc_t head_desc
);

  localparam int PTR_W = $clog2(gfm_pkg::QDEPTH);
  localparam int CNT_W = $clog2(gfm_pkg::QDEPTH + 1);

  gfm_pkg::desc_t   mem [gfm_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign push_ready = count_r != CNT_W'(gfm_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_desc  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/gfm_back.sv */
// back end: sequences vertex and triangle corner results into the output register
module gfm_back #(
  parameter int CD_W = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  gfm_pkg::desc_t               head_desc,
  output logic                         pop,
  input  logic [CD_W-1:0]              cols,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [gfm_pkg::IDX_W-1:0]    out_idx,
  output logic [gfm_pkg::COORD_W-1:0]  out_pos_x,
  output logic [gfm_pkg::COORD_W-1:0]  out_pos_z,
  output logic [gfm_pkg::COORD_W-1:0]  out_tex_u,
  output logic [gfm_pkg::COORD_W-1:0]  out_tex_v,
  output logic                         out_last
);

  gfm_pkg::desc_t                cur_r;
  logic                          busy_r, busy_nxt;
  logic                          corner_r, corner_nxt;
  logic [gfm_pkg::TRI_W-1:0]     t_r, t_nxt;
  logic [1:0]                    k_r, k_nxt;
  logic [gfm_pkg::NTRI-1:0]      rem_r, rem_nxt, rem_clr;
  logic                          out_valid_r;
  logic                          can_out, emit, res_last;
  logic [gfm_pkg::IDX_W-1:0]     res_idx;
  gfm_pkg::corner_t              sel;

  function automatic logic [gfm_pkg::TRI_W-1:0] first_set(input logic [gfm_pkg::NTRI-1:0] m);
    logic [gfm_pkg::TRI_W-1:0] r;
    r = '0;
    for (int i = gfm_pkg::NTRI - 1; i >= 0; i--) begin
      if (m[i]) r = gfm_pkg::TRI_W'(i);
    end
    return r;
  endfunction

  assign can_out   = !out_valid_r || out_ready;
  assign emit      = busy_r && can_out;
  assign out_valid = out_valid_r;

  always_comb begin
    rem_clr = rem_r & ~(gfm_pkg::NTRI'(1) << t_r);
    if (k_r == 2'd0) begin
      sel = gfm_pkg::CN_C;
    end else begin
      sel = gfm_pkg::fan_corner(t_r, k_r == 2'd2);
    end
    res_idx  = gfm_pkg::corner_index(cur_r.idx, gfm_pkg::IDX_W'(cols), sel);
    res_last = corner_r ? ((k_r == 2'd2) && (rem_clr == '0)) : !cur_r.center;

    pop        = head_valid && (!busy_r || (emit && res_last));
    busy_nxt   = busy_r;
    corner_nxt = corner_r;
    t_nxt      = t_r;
    k_nxt      = k_r;
    rem_nxt    = rem_r;
    if (emit) begin
      if (res_last) begin
        busy_nxt = 1'b0;
      end else if (!corner_r) begin
        corner_nxt = 1'b1;
        rem_nxt    = cur_r.tri_mask;
        t_nxt      = first_set(cur_r.tri_mask);
        k_nxt      = 2'd0;
      end else if (k_r == 2'd2) begin
        k_nxt   = 2'd0;
        rem_nxt = rem_clr;
        t_nxt   = first_set(rem_clr);
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end
    if (pop) begin
      busy_nxt   = 1'b1;
      corner_nxt = 1'b0;
      k_nxt      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_desc;
    end
    if (emit) begin
      out_kind  <= corner_r;
      out_idx   <= corner_r ? res_idx : cur_r.idx;
      out_pos_x <= corner_r ? '0 : cur_r.pos_x;
      out_pos_z <= corner_r ? '0 : cur_r.pos_z;
      out_tex_u <= corner_r ? '0 : cur_r.tex_u;
      out_tex_v <= corner_r ? '0 : cur_r.tex_v;
      out_last  <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      corner_r    <= 1'b0;
      t_r         <= '0;
      k_r         <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      corner_r <= corner_nxt;
      t_r      <= t_nxt;
      k_r      <= k_nxt;
      rem_r    <= rem_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/grid_fan_mesh_index_generator.sv */
// Grid fan mesh index generator: walks a vertex grid row-major, one vertex per input
// transfer, and gives a vertex result followed, at odd row and odd column, by fan
// triangle corner indices. The input side takes one step per cycle while the
// two-entry descriptor queue has room. The output sequencer gives one result per
// cycle while the output is not stalled; a fan center with 2, 4 or 8 triangles adds
// three corner indices per triangle; the sustained rate is set by that sequencer.
// There is no clearing pass after reset.
module grid_fan_mesh_index_generator #(
  parameter int MAX_COLUMNS = gfm_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gfm_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gfm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [gfm_pkg::IN_W-1:0]      in_tdata,   // restart
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [gfm_pkg::OUT_W-1:0]     out_tdata,  // index_value, pos_x, pos_z, tex_u, tex_v
  output logic [0:0]                    out_tuser,  // kind
  output logic                          out_tlast
);

  localparam int CD_W = $clog2(MAX_COLUMNS + 1);

  gfm_pkg::desc_t              push_desc, head_desc;
  logic                        step, q_ready, head_valid, pop;
  logic [CD_W-1:0]             cols;
  logic                        o_kind;
  logic [gfm_pkg::IDX_W-1:0]   o_idx;
  logic [gfm_pkg::COORD_W-1:0] o_px, o_pz, o_tu, o_tv;

  assign in_tready = q_ready;
  assign step      = in_tvalid && q_ready;

  gfm_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .restart   (in_tdata[0]),
    .desc      (push_desc),
    .cols      (cols)
  );

  gfm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .push_desc  (push_desc),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  gfm_back #(
    .CD_W (CD_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .cols       (cols),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (o_kind),
    .out_idx    (o_idx),
    .out_pos_x  (o_px),
    .out_pos_z  (o_pz),
    .out_tex_u  (o_tu),
    .out_tex_v  (o_tv),
    .out_last   (out_tlast)
  );

  assign out_tdata = gfm_pkg::OUT_W'({o_tv, o_tu, o_pz, o_px, o_idx});
  assign out_tuser = o_kind;

endmodule

/* rtl/gfm_checker.sv */
// port-level checker for the grid fan mesh index generator and its bind
module gfm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [gfm_pkg::OUT_W-1:0] out_tdata,
  input logic [0:0]                out_tuser,
  input logic                      out_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_corner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[gfm_pkg::OUT_W-1:gfm_pkg::IDX_W] == '0)
    else $error("triangle corner carries coordinates");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind grid_fan_mesh_index_generator gfm_checker u_gfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* tb/grid_fan_mesh_index_generator_chk.sv */
// result checker for the grid fan mesh index generator: tracks the registers, predicts, compares
module grid_fan_mesh_index_generator_chk
  import gfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // restart
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_W-1:0]     out_tdata,  // index_value, pos_x, pos_z, tex_u, tex_v
  input  logic [0:0]           out_tuser,  // kind
  input  logic                 out_tlast,
  output int                   mismatches,
  output int                   pending,
  output int                   results_checked,
  output int                   fan_centers
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] pz;
    logic [COORD_W-1:0] tu;
    logic [COORD_W-1:0] tv;
    logic               last;
  } mesh_result_t;

  // second and third corner of each fan triangle, in fan order
  corner_t fan_pair [0:2*NTRI-1] = '{CN_UL, CN_CL, CN_UC, CN_UL, CN_UR, CN_UC, CN_CR, CN_UR,
                                     CN_LR, CN_CR, CN_LC, CN_LR, CN_LL, CN_LC, CN_CL, CN_LL};

  logic [DIM_W-1:0]   grid_columns;
  logic [DIM_W-1:0]   grid_rows;
  logic [COORD_W-1:0] step_a;
  logic [COORD_W-1:0] step_b;

  logic [9:0]         row_pos;
  logic [9:0]         col_pos;
  logic [IDX_W-1:0]   vtx_index;
  logic [COORD_W-1:0] col_sum_b;
  logic [COORD_W-1:0] col_sum_a;
  logic [COORD_W-1:0] row_sum_a;
  logic [COORD_W-1:0] row_sum_b;

  mesh_result_t awaited_results [$];

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] add_sat(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_W] ? {COORD_W{1'b1}} : s[COORD_W-1:0];
  endfunction

  task automatic clear_walk();
    row_pos   = '0;
    col_pos   = '0;
    vtx_index = '0;
    col_sum_b = '0;
    col_sum_a = '0;
    row_sum_a = '0;
    row_sum_b = '0;
  endtask

  task automatic advance_vertex(input logic restart);
    int unsigned  cols;
    int unsigned  rows;
    int unsigned  n;
    int unsigned  next_col;
    int unsigned  next_row;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] cw;
    logic [IDX_W-1:0] nb [0:8];
    logic [NTRI-1:0]  tri_on;
    logic         row_end;
    logic         col_end;
    mesh_result_t step_out [0:24];
    cols = clamp_dim(grid_columns, MAX_COLUMNS_DEF);
    rows = clamp_dim(grid_rows, MAX_ROWS_DEF);
    if (restart || row_pos >= rows || col_pos >= cols) clear_walk();
    step_out[0] = '{kind: 1'b0, idx: vtx_index, px: col_sum_b, pz: row_sum_a,
                    tu: row_sum_b, tv: col_sum_a, last: 1'b0};
    n = 1;
    if (row_pos[0] && col_pos[0]) begin
      fan_centers++;
      c  = vtx_index;
      cw = IDX_W'(cols);
      nb[int'(CN_C)]  = c;
      nb[int'(CN_UL)] = c - cw - 1'b1;
      nb[int'(CN_UC)] = c - cw;
      nb[int'(CN_UR)] = c - cw + 1'b1;
      nb[int'(CN_CL)] = c - 1'b1;
      nb[int'(CN_CR)] = c + 1'b1;
      nb[int'(CN_LL)] = c + cw - 1'b1;
      nb[int'(CN_LC)] = c + cw;
      nb[int'(CN_LR)] = c + cw + 1'b1;
      row_end = (row_pos == rows - 1);
      col_end = (col_pos == cols - 1);
      if (row_end && col_end) tri_on = 8'b0000_0011;
      else if (col_end) tri_on = 8'b1100_0011;
      else if (row_end) tri_on = 8'b0000_1111;
      else tri_on = 8'b1111_1111;
      for (int t = 0; t < NTRI; t++) begin
        if (tri_on[t]) begin
          step_out[n]     = '{kind: 1'b1, idx: c, default: '0};
          step_out[n + 1] = '{kind: 1'b1, idx: nb[int'(fan_pair[2*t])], default: '0};
          step_out[n + 2] = '{kind: 1'b1, idx: nb[int'(fan_pair[2*t + 1])], default: '0};
          n += 3;
        end
      end
    end
    step_out[n - 1].last = 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      awaited_results.insert(awaited_results.size(), step_out[k]);
    end

    vtx_index = vtx_index + 1'b1;
    next_col  = col_pos + 1;
    if (next_col >= cols) begin
      col_pos   = '0;
      col_sum_b = '0;
      col_sum_a = '0;
      next_row  = row_pos + 1;
      row_sum_a = add_sat(row_sum_a, step_a);
      row_sum_b = add_sat(row_sum_b, step_b);
      if (next_row >= rows) clear_walk();
      else row_pos = 10'(next_row);
    end else begin
      col_pos   = 10'(next_col);
      col_sum_b = add_sat(col_sum_b, step_b);
      col_sum_a = add_sat(col_sum_a, step_a);
    end
  endtask

  task automatic note_mismatch(input string what, input mesh_result_t want,
                               input mesh_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s after %0d results", $realtime, what, results_checked);
      $display("  expected kind %0d idx %0d x %0d z %0d u %0d v %0d last %0d",
               want.kind, want.idx, want.px, want.pz, want.tu, want.tv, want.last);
      $display("  actual   kind %0d idx %0d x %0d z %0d u %0d v %0d last %0d",
               got.kind, got.idx, got.px, got.pz, got.tu, got.tv, got.last);
    end
  endtask

  task automatic check_result();
    mesh_result_t got;
    mesh_result_t want;
    got.kind = out_tuser[0];
    got.idx  = out_tdata[IDX_W-1:0];
    got.px   = out_tdata[IDX_W +: COORD_W];
    got.pz   = out_tdata[IDX_W + COORD_W +: COORD_W];
    got.tu   = out_tdata[IDX_W + 2*COORD_W +: COORD_W];
    got.tv   = out_tdata[IDX_W + 3*COORD_W +: COORD_W];
    got.last = out_tlast;
    if (awaited_results.size() == 0) begin
      note_mismatch("result with nothing awaited", '0, got);
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) note_mismatch("result mismatch", want, got);
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      grid_columns    = DIM_W'(2);
      grid_rows       = DIM_W'(2);
      step_a          = COORD_W'(65536);
      step_b          = COORD_W'(65536);
      clear_walk();
      awaited_results.delete();
      mismatches      = 0;
      results_checked = 0;
      fan_centers     = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_COLUMNS: grid_columns = cfg_data[DIM_W-1:0];
          REG_ROWS:    grid_rows    = cfg_data[DIM_W-1:0];
          REG_STEP_A:  step_a       = cfg_data[COORD_W-1:0];
          REG_STEP_B:  step_b       = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) advance_vertex(in_tdata[0]);
      if (out_tvalid && out_tready) check_result();
    end
    pending = awaited_results.size();
  end

endmodule

/* tb/grid_fan_mesh_index_generator_tb.sv */
// testbench top for the grid fan mesh index generator: clock, reset, stimulus and verdict
module grid_fan_mesh_index_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gfm_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // restart
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;       // index_value, pos_x, pos_z, tex_u, tex_v
  logic [0:0]           out_tuser;       // kind
  logic                 out_tlast;

  int mismatches;
  int pending;
  int results_checked;
  int fan_centers;

  bit          burst;
  logic        sink_fast = 1'b0;
  int unsigned sink_wait = 0;
  int unsigned n_items;
  int unsigned n_random;
  int unsigned n_settings;

  grid_fan_mesh_index_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  grid_fan_mesh_index_generator_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .fan_centers     (fan_centers)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random hold-off after each transfer unless sink_fast is set
  always @(posedge clk) begin
    int unsigned hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        hold = sink_fast ? 0 : $urandom_range(0, 8);
        if (hold != 0) begin
          out_tready <= 1'b0;
          sink_wait  <= hold;
        end
      end
    end else if (sink_wait <= 1) begin
      out_tready <= 1'b1;
      sink_wait  <= 0;
    end else begin
      sink_wait <= sink_wait - 1;
    end
  end

  task automatic put_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_grid_setup(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                                 input logic [COORD_W-1:0] sa, input logic [COORD_W-1:0] sb);
    put_reg(REG_COLUMNS, CFG_W'(cols));
    put_reg(REG_ROWS, CFG_W'(rows));
    put_reg(REG_STEP_A, CFG_W'(sa));
    put_reg(REG_STEP_B, CFG_W'(sb));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send_step(input logic restart);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-1){1'b0}}, restart};
    do @(posedge clk); while (!in_tready);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return '1;
      3:       return DIM_W'(1024);
      4:       return DIM_W'($urandom_range(0, 2047));
      default: return DIM_W'($urandom_range(2, 9));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COORD_W'(65536);
      2:       return '1;
      default: return COORD_W'($urandom_range(0, 131071));
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned count;
    n_items    = 0;
    n_random   = 0;
    n_settings = 0;
    burst      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid of 2 x 2, its only center sits on both edges
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    drain();

    // 4 x 4 covers inner, right edge, bottom edge and corner fans, then wraps
    load_grid_setup(DIM_W'(4), DIM_W'(4), COORD_W'(21845), COORD_W'(21845));
    sink_fast <= 1'b1;
    burst = 1'b1;
    repeat (19) send_step(1'b0);
    drain();

    // shrunk grid puts the walk outside, clamped rows, saturating sums, restart
    load_grid_setup(DIM_W'(3), '0, '1, '1);
    sink_fast <= 1'b0;
    burst = 1'b0;
    repeat (5) send_step(1'b0);
    send_step(1'b1);

    phase = 0;
    while (n_random < 80) begin
      drain();
      case (phase)
        0:       load_grid_setup('1, DIM_W'(1024), '0, COORD_W'(65536));
        1:       load_grid_setup(DIM_W'(1024), '1, COORD_W'(65536), '0);
        default: load_grid_setup(pick_dim(), pick_dim(), pick_step(), pick_step());
      endcase
      burst = ($urandom_range(0, 3) == 0);
      sink_fast <= ($urandom_range(0, 3) == 0);
      count = $urandom_range(4, 24);
      repeat (count) begin
        if ($urandom_range(0, 24) == 0) drain();
        send_step($urandom_range(0, 11) == 0);
        n_random++;
      end
      phase++;
    end

    drain();
    repeat (30) @(posedge clk);
    $display("covered %0d vertex steps over %0d grid setups", n_items, n_settings);
    $display("checked %0d results, %0d fan centers", results_checked, fan_centers);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
